FILE: rtl/lpfr_pkg.sv
package lpfr_pkg;

  localparam int DEF_MAX_FRAMES = 8;
  localparam int DEF_PAGE_BITS  = 16;

  localparam int CFG_W       = 4;
  localparam int FRAME_IDX_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic fault;
    logic evicted_valid;
  } lookup_flags_t;

endpackage

FILE: rtl/lpfr_frame_table.sv
module lpfr_frame_table #(
  parameter int MAX_FRAMES = lpfr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = lpfr_pkg::DEF_PAGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lpfr_pkg::CFG_W-1:0]    frames_in_use,
  input  logic                          ref_en,
  input  logic [PAGE_BITS-1:0]          ref_page,
  output lpfr_pkg::lookup_flags_t       flags,
  output logic [lpfr_pkg::FRAME_IDX_W-1:0] frame_index,
  output logic [PAGE_BITS-1:0]          evicted_page
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AGE_W = IDX_W;
  localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(MAX_FRAMES - 1);

  logic [PAGE_BITS-1:0]  page_r  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r;
  logic [AGE_W-1:0]      age_r   [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_nxt;
  logic [AGE_W-1:0]      age_nxt [MAX_FRAMES];

  logic [MAX_FRAMES-1:0] in_use;
  logic [MAX_FRAMES-1:0] hit_vec;
  logic [MAX_FRAMES-1:0] empty_vec;
  logic [MAX_FRAMES-1:0] oldest_vec;
  logic [MAX_FRAMES-1:0] sel_vec;
  logic [MAX_FRAMES-1:0] target_oh;
  logic [IDX_W-1:0]      target;
  logic                  hit;
  logic                  empty;
  logic [AGE_W-1:0]      target_age;
  logic [PAGE_BITS-1:0]  target_page;

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      if (frames_in_use == '0) begin
        in_use[j] = (j == 0);
      end else begin
        in_use[j] = (j < 32'(frames_in_use));
      end
      hit_vec[j]   = in_use[j] && valid_r[j] && (page_r[j] == ref_page);
      empty_vec[j] = in_use[j] && !valid_r[j];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      oldest_vec[j] = in_use[j];
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if (in_use[k] && (age_r[k] > age_r[j])) begin
          oldest_vec[j] = 1'b0;
        end
      end
    end
  end

  assign hit   = |hit_vec;
  assign empty = |empty_vec;

  always_comb begin
    if (hit) begin
      sel_vec = hit_vec;
    end else if (empty) begin
      sel_vec = empty_vec;
    end else begin
      sel_vec = oldest_vec;
    end
    target    = '0;
    target_oh = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (sel_vec[j]) begin
        target    = IDX_W'(j);
        target_oh = '0;
        target_oh[j] = 1'b1;
      end
    end
  end

  always_comb begin
    target_age  = '0;
    target_page = '0;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      if (target_oh[j]) begin
        target_age  = target_age | age_r[j];
        target_page = target_page | page_r[j];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      age_nxt[j] = age_r[j];
      if (target_oh[j]) begin
        age_nxt[j]   = '0;
        valid_nxt[j] = 1'b1;
      end else if (in_use[j] && valid_r[j] && (age_r[j] < AGE_TOP) &&
                   ((!hit && empty) || (age_r[j] < target_age))) begin
        age_nxt[j] = age_r[j] + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        age_r[j] <= '0;
      end
    end else if (ref_en) begin
      valid_r <= valid_nxt;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        age_r[j] <= age_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ref_en && !hit) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (target_oh[j]) begin
          page_r[j] <= ref_page;
        end
      end
    end
  end

  assign flags.fault         = !hit;
  assign flags.evicted_valid = !hit && !empty;
  assign frame_index         = lpfr_pkg::FRAME_IDX_W'(target);
  assign evicted_page        = (!hit && !empty) ? target_page : '0;

endmodule

FILE: rtl/lru_page_frame_replacer_unit.sv
// LRU page frame replacer.
// Input channel: in_valid/in_ready carry one page reference per item (in_page).
// Result channel: out_valid/out_ready carry one result per item: out_fault,
// out_frame_index, out_evicted_valid and out_evicted_page.
// Config: cfg_we/cfg_wdata write the frame count (1..8; 0 acts as 1, larger
// values act as MAX_FRAMES). Write only while no item is in flight.
// Path: an accepted item passes the input register and then the result
// register, where out_valid rises; two register stages in all.
// Throughput: one item per cycle while out_ready is high; the frame compare,
// victim pick and rank update all close combinationally between the registers.
// Reset: all frames empty, all ranks zero, frame count 8, both registers empty.
// Stall: while out_ready is low the result holds; one more item waits in the
// input register, after which in_ready drops until the result is taken.
module lru_page_frame_replacer_unit #(
  parameter int MAX_FRAMES = lpfr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = lpfr_pkg::DEF_PAGE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PAGE_BITS-1:0]             in_page,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_fault,
  output logic [lpfr_pkg::FRAME_IDX_W-1:0] out_frame_index,
  output logic                             out_evicted_valid,
  output logic [PAGE_BITS-1:0]             out_evicted_page,
  input  logic                             cfg_we,
  input  logic [lpfr_pkg::CFG_W-1:0]       cfg_wdata
);

  logic                             in_valid_r;
  logic [PAGE_BITS-1:0]             in_page_r;
  logic                             out_valid_r;
  logic                             fault_r;
  logic [lpfr_pkg::FRAME_IDX_W-1:0] frame_index_r;
  logic                             evicted_valid_r;
  logic [PAGE_BITS-1:0]             evicted_page_r;
  logic [lpfr_pkg::CFG_W-1:0]       frames_in_use_r;

  logic                             advance;
  lpfr_pkg::lookup_flags_t          flags;
  logic [lpfr_pkg::FRAME_IDX_W-1:0] frame_index;
  logic [PAGE_BITS-1:0]             evicted_page;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  lpfr_frame_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .frames_in_use (frames_in_use_r),
    .ref_en        (advance),
    .ref_page      (in_page_r),
    .flags         (flags),
    .frame_index   (frame_index),
    .evicted_page  (evicted_page)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lpfr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_page_r <= in_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fault_r         <= flags.fault;
      frame_index_r   <= frame_index;
      evicted_valid_r <= flags.evicted_valid;
      evicted_page_r  <= evicted_page;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_frame_index   = frame_index_r;
  assign out_evicted_valid = evicted_valid_r;
  assign out_evicted_page  = evicted_page_r;

endmodule
